// ===== design/dbf_pkg.sv =====
package dbf_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned AGE_W  = 16;
  localparam int unsigned TMO_W  = 16;

  localparam logic [AGE_W-1:0] AGE_MAX       = '1;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10;

  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_NEW   = 2'd0,
    VERDICT_NEWER = 2'd1,
    VERDICT_DUP   = 2'd2,
    VERDICT_FULL  = 2'd3
  } verdict_e;

  // lookup token that walks down the cell row
  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic              hit;
    logic              newer;
    logic              free_found;
  } tok_t;

  // insert broadcast from the end of the row
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
  } ins_t;

endpackage

// ===== design/dbf_if.sv =====
interface dbf_in_if
  import dbf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] source_address;
  logic [SEQ_W-1:0]  sequence_number;

  modport source (output valid, mode, source_address, sequence_number, input ready);
  modport sink   (input valid, mode, source_address, sequence_number, output ready);
endinterface

interface dbf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// ===== design/duplicate_broadcast_filter.sv =====
// Duplicate broadcast filter: one table slot per source MAC address, holding
// the newest accepted sequence number and an age in seconds.
// Channels: in_i takes beats of mode, source_address and sequence_number;
// mode 0 checks a packet, mode 1 is a one-second tick that ages all slots.
// out_o gives one verdict beat per packet (none per tick): new source, newer
// sequence, duplicate, or table full.
// Config: cfg_we_i/cfg_wdata_i write timeout_seconds, reset value 10.
// Walk: a beat walks the row of TABLE_ENTRIES cells, one cell per cycle, and
// its verdict is registered when it leaves the last cell.
// The input stays closed while a beat walks the row; a tick reopens it at the
// end of the walk, a packet once its verdict is in the output register.
// A free source is inserted into the lowest free slot at the end of the walk.
// Stall: a verdict waits in the output register, a second in a hold register;
// input beats are taken while only the output register holds a verdict.
// Reset: all slots are empty, the timeout returns to 10, no verdict pending.
module duplicate_broadcast_filter
  import dbf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TMO_W-1:0] cfg_wdata_i,
  dbf_in_if.sink           in_i,
  dbf_out_if.source        out_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TMO_W-1:0] timeout_q;
  logic             busy_q;
  logic             out_valid_q;
  verdict_e         out_verdict_q;
  logic             pend_q;
  verdict_e         pend_verdict_q;

  tok_t             tok_w  [TABLE_ENTRIES+1];
  logic [IW-1:0]    fidx_w [TABLE_ENTRIES+1];
  ins_t             ins;
  tok_t             last;
  verdict_e         verdict_c;
  logic             in_fire, done_pkt, done_tick, out_free;

  assign in_i.ready = !busy_q;
  assign in_fire    = in_i.valid && !busy_q;

  // token entering the first cell
  always_comb begin
    tok_w[0].valid      = in_fire;
    tok_w[0].mode       = in_i.mode;
    tok_w[0].addr       = in_i.source_address;
    tok_w[0].seq        = in_i.sequence_number;
    tok_w[0].hit        = 1'b0;
    tok_w[0].newer      = 1'b0;
    tok_w[0].free_found = 1'b0;
  end
  assign fidx_w[0] = '0;

  // cell row
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    dbf_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .timeout_i (timeout_q),
      .tok_i     (tok_w[g]),
      .fidx_i    (fidx_w[g]),
      .ins_i     (ins),
      .ins_idx_i (fidx_w[TABLE_ENTRIES]),
      .tok_o     (tok_w[g+1]),
      .fidx_o    (fidx_w[g+1])
    );
  end

  // end of the walk: verdict and insert into the lowest free slot
  assign last      = tok_w[TABLE_ENTRIES];
  assign done_pkt  = last.valid && (last.mode == MODE_PACKET);
  assign done_tick = last.valid && (last.mode == MODE_TICK);
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    priority if (last.hit) begin
      verdict_c = last.newer ? VERDICT_NEWER : VERDICT_DUP;
    end else if (last.free_found) begin
      verdict_c = VERDICT_NEW;
    end else begin
      verdict_c = VERDICT_FULL;
    end
  end

  assign ins.valid = done_pkt && !last.hit && last.free_found;
  assign ins.addr  = last.addr;
  assign ins.seq   = last.seq;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // busy, hold and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end
      if (done_tick) begin
        busy_q <= 1'b0;
      end
      if (done_pkt) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
          busy_q      <= 1'b0;
        end else begin
          pend_q <= 1'b1;
        end
      end else if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
        busy_q      <= 1'b0;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // verdict payload
  always_ff @(posedge clk_i) begin
    if (done_pkt) begin
      if (out_free) begin
        out_verdict_q <= verdict_c;
      end else begin
        pend_verdict_q <= verdict_c;
      end
    end else if (pend_q && out_free) begin
      out_verdict_q <= pend_verdict_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.verdict = out_verdict_q;

endmodule

// ===== design/dbf_cell.sv =====
module dbf_cell
  import dbf_pkg::*;
#(
  parameter int unsigned IW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TMO_W-1:0] timeout_i,
  input  tok_t             tok_i,
  input  logic [IW-1:0]    fidx_i,
  input  ins_t             ins_i,
  input  logic [IW-1:0]    ins_idx_i,
  output tok_t             tok_o,
  output logic [IW-1:0]    fidx_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic              valid_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [AGE_W-1:0]  age_q;
  tok_t              tok_q, tok_d;
  logic [IW-1:0]     fidx_q, fidx_d;

  logic              match;
  logic [SEQ_W-1:0]  diff;
  logic              is_newer;
  logic [AGE_W-1:0]  age_inc;
  logic              pkt, tick, ins_here;

  // address match, serial number compare against the stored sequence, age step
  assign match    = valid_q && (addr_q == tok_i.addr);
  assign diff     = tok_i.seq - seq_q;
  assign is_newer = (diff != '0) && !diff[SEQ_W-1];
  assign age_inc  = (age_q == AGE_MAX) ? age_q : age_q + AGE_W'(1);

  assign pkt      = tok_i.valid && (tok_i.mode == MODE_PACKET);
  assign tick     = tok_i.valid && (tok_i.mode == MODE_TICK);
  assign ins_here = ins_i.valid && (ins_idx_i == MyIdx);

  // token update as it passes this slot
  always_comb begin
    tok_d  = tok_i;
    fidx_d = fidx_i;
    if (pkt && match && !tok_i.hit) begin
      tok_d.hit   = 1'b1;
      tok_d.newer = is_newer;
    end
    if (pkt && !valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      fidx_d           = MyIdx;
    end
  end

  // token hand-off to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      fidx_q <= '0;
    end else begin
      tok_q  <= tok_d;
      fidx_q <= fidx_d;
    end
  end

  // slot valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ins_here) begin
      valid_q <= 1'b1;
    end else if (tick && valid_q && (age_inc >= timeout_i)) begin
      valid_q <= 1'b0;
    end
  end

  // slot contents
  always_ff @(posedge clk_i) begin
    if (ins_here) begin
      addr_q <= ins_i.addr;
      seq_q  <= ins_i.seq;
      age_q  <= '0;
    end else if (pkt && match && !tok_i.hit && is_newer) begin
      seq_q <= tok_i.seq;
      age_q <= '0;
    end else if (tick && valid_q) begin
      age_q <= age_inc;
    end
  end

  assign tok_o  = tok_q;
  assign fidx_o = fidx_q;

endmodule

// ===== design/dbf_checker.sv =====
module dbf_checker #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_verdict_i
);

  // a verdict beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("verdict dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_verdict_i))
    else $error("verdict changed while stalled");

  // one beat at a time through the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##TABLE_ENTRIES !in_ready_i)
    else $error("input taken before the walk finished");

  // a fresh verdict only follows a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("verdict appeared with no beat in flight");

endmodule

bind duplicate_broadcast_filter dbf_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_dbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_verdict_i (out_o.verdict)
);

// ===== test/duplicate_broadcast_filter_tb.sv =====
module duplicate_broadcast_filter_tb
  import dbf_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SEG_ITEMS     = 325;
  localparam int unsigned POOL_MAX      = 64;

  // tracks the source table and the verdicts still owed by the block
  class filter_board;
    bit                used      [TABLE_ENTRIES];
    logic [ADDR_W-1:0] addr_tab  [TABLE_ENTRIES];
    logic [SEQ_W-1:0]  seq_tab   [TABLE_ENTRIES];
    logic [AGE_W-1:0]  age_tab   [TABLE_ENTRIES];
    logic [TMO_W-1:0]  hold_secs;
    verdict_e          verdicts_due[$];
    int unsigned       errors;

    function new();
      hold_secs = TIMEOUT_RESET;
      errors    = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    // serial number compare over 16 bits, half range counts as not newer
    function bit seq_newer(logic [SEQ_W-1:0] stored, logic [SEQ_W-1:0] incoming);
      logic [SEQ_W-1:0] diff;
      diff = incoming - stored;
      return (diff != '0) && !diff[SEQ_W-1];
    endfunction

    // one-second tick: age every live slot, drop the expired ones
    function void age_slots();
      foreach (used[i]) begin
        if (used[i]) begin
          if (age_tab[i] != AGE_MAX) age_tab[i] = age_tab[i] + 1'b1;
          if (age_tab[i] >= hold_secs) used[i] = 1'b0;
        end
      end
    endfunction

    function verdict_e judge_packet(logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq);
      int free_idx;
      free_idx = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (used[i]) begin
          if (addr_tab[i] == addr) begin
            if (seq_newer(seq_tab[i], seq)) begin
              seq_tab[i] = seq;
              age_tab[i] = '0;
              return VERDICT_NEWER;
            end
            return VERDICT_DUP;
          end
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (free_idx < 0) return VERDICT_FULL;
      used[free_idx]     = 1'b1;
      addr_tab[free_idx] = addr;
      seq_tab[free_idx]  = seq;
      age_tab[free_idx]  = '0;
      return VERDICT_NEW;
    endfunction

    function void note_beat(logic mode, logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq);
      if (mode == MODE_TICK) age_slots();
      else verdicts_due.push_back(judge_packet(addr, seq));
    endfunction

    function void check_verdict(logic [1:0] got);
      verdict_e want;
      if (verdicts_due.size() == 0) begin
        $display("%0t unexpected verdict beat: actual %0d", $time, got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got !== want) begin
        $display("%0t verdict mismatch: expected %0d (%s), actual %0d",
                 $time, want, want.name(), got);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TMO_W-1:0] cfg_wdata_i;

  dbf_in_if  in_ch ();
  dbf_out_if out_ch ();

  filter_board       board;
  int unsigned       src_idle_pct;
  int unsigned       sink_stall_pct;
  int unsigned       cycle_count = 0;
  logic [ADDR_W-1:0] pool_addr [POOL_MAX];
  logic [SEQ_W-1:0]  pool_seq  [POOL_MAX];

  duplicate_broadcast_filter #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // random backpressure on the verdict channel
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // observe accepted beats on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        board.note_beat(in_ch.mode, in_ch.source_address, in_ch.sequence_number);
      if (out_ch.valid && out_ch.ready)
        board.check_verdict(out_ch.verdict);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(input logic mode, input logic [ADDR_W-1:0] addr,
                           input logic [SEQ_W-1:0] seq);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= mode;
    in_ch.source_address  <= addr;
    in_ch.sequence_number <= seq;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop sending and hold off until every owed verdict has come back
  task automatic wait_verdicts();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // ticks leave no verdict, so give the cell row time to empty as well
  task automatic drain_block();
    wait_verdicts();
    repeat (TABLE_ENTRIES + 4) @(posedge clk_i);
  endtask

  task automatic write_hold(input logic [TMO_W-1:0] secs);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= secs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.hold_secs = secs;
  endtask

  task automatic run_directed();
    logic [ADDR_W-1:0] top_addr;
    top_addr = '1;
    // insert, equal, newer, half-range, wrap-around newer
    send_beat(MODE_PACKET, '0, 16'h0000);
    send_beat(MODE_PACKET, '0, 16'h0000);
    send_beat(MODE_PACKET, '0, 16'h0001);
    send_beat(MODE_PACKET, '0, 16'h8001);
    send_beat(MODE_PACKET, '0, 16'h8000);
    send_beat(MODE_PACKET, top_addr, 16'hffff);
    send_beat(MODE_PACKET, top_addr, 16'h0000);
    // tick carries junk payload and gives no verdict
    send_beat(MODE_TICK, ADDR_W'({$urandom, $urandom}), 16'($urandom));
    send_beat(MODE_PACKET, '0, 16'h7fff);
    send_beat(MODE_PACKET, top_addr, 16'h7fff);
    send_beat(MODE_PACKET, top_addr, 16'h8000);
    // zero hold time clears every slot on a tick
    drain_block();
    write_hold('0);
    send_beat(MODE_TICK, '1, '1);
    send_beat(MODE_PACKET, '0, 16'h0005);
    send_beat(MODE_PACKET, top_addr, 16'h1234);
    send_beat(MODE_TICK, '0, '0);
    send_beat(MODE_PACKET, top_addr, 16'h1234);
    drain_block();
  endtask

  task automatic run_segment(input int unsigned pool_n, input int unsigned tick_pct,
                             input bit mid_pause);
    int unsigned       k;
    int unsigned       pick;
    logic [SEQ_W-1:0]  s;
    for (int unsigned i = 0; i < pool_n; i++) begin
      pool_addr[i] = ADDR_W'({$urandom, $urandom});
      pool_seq[i]  = 16'($urandom);
    end
    for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
      if (mid_pause && n == SEG_ITEMS / 2) wait_verdicts();
      if ($urandom_range(99) < tick_pct) begin
        send_beat(MODE_TICK, ADDR_W'({$urandom, $urandom}), 16'($urandom));
      end else if ($urandom_range(99) < 8) begin
        // stray source outside the pool
        send_beat(MODE_PACKET, ADDR_W'({$urandom, $urandom}), 16'($urandom));
      end else begin
        k    = $urandom_range(pool_n - 1);
        pick = $urandom_range(99);
        if (pick < 55) s = pool_seq[k] + 16'($urandom_range(1, 4));
        else if (pick < 70) s = pool_seq[k];
        else if (pick < 80) s = pool_seq[k] - 16'($urandom_range(1, 4));
        else if (pick < 86) s = pool_seq[k] + 16'h8000;
        else if (pick < 92) s = pool_seq[k] + 16'h7fff;
        else s = 16'($urandom);
        if (pick < 55 || pick >= 92) pool_seq[k] = s;
        send_beat(MODE_PACKET, pool_addr[k], s);
      end
    end
    drain_block();
  endtask

  initial begin
    board          = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid           = 1'b0;
    in_ch.mode            = MODE_PACKET;
    in_ch.source_address  = '0;
    in_ch.sequence_number = '0;
    src_idle_pct   = 18;
    sink_stall_pct = 50;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // sender idles lightly, receiver stalls hard
    write_hold('1);
    run_segment(48, 6, 1'b1);
    write_hold(16'd1);
    run_segment(20, 10, 1'b0);

    // the other way round
    src_idle_pct   = 50;
    sink_stall_pct = 18;
    write_hold(16'd3);
    run_segment(40, 8, 1'b0);
    write_hold(16'($urandom_range(2, 12)));
    run_segment(36, 12, 1'b0);

    // back to back on both sides
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_hold(TIMEOUT_RESET);
    run_segment(24, 10, 1'b0);
    write_hold('1);
    run_segment(34, 4, 1'b0);

    if (board.errors == 0 && board.verdicts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dbf_pkg.sv
design/dbf_if.sv
design/dbf_cell.sv
design/duplicate_broadcast_filter.sv
design/dbf_checker.sv
test/duplicate_broadcast_filter_tb.sv
